>>> hdl/fpfa_pkg.sv
// Shared codes and types for the fixed-partition fit allocator.
// No dependencies; imported by fpfa_cell and the core top level.
package fpfa_pkg;

  // item modes
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_ALLOC = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // placement policies (unused code falls back to first fit)
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // fixed port widths
  localparam int MODE_W     = 2;
  localparam int SIZE_IN_W  = 16;
  localparam int IDX_OUT_W  = 4;
  localparam int SIZE_OUT_W = 16;
  localparam int FREE_W     = 20;
  localparam logic [FREE_W-1:0] FREE_MAX = {FREE_W{1'b1}};

  // per-cell update strobes from the controller
  typedef struct packed {
    logic clr;  // drop the entry (table clear)
    logic ld;   // store a new partition size
    logic gnt;  // mark the partition as used
  } cell_ctl_t;

endpackage

>>> hdl/fixed_partition_fit_allocator_core.sv
// Top level of the fixed-partition fit allocator: controller, free total
// and a chain of fpfa_cell slots. Depends on fpfa_pkg and fpfa_cell.
//
// Usage: an item is taken when start is high and busy is low; each item
// gives one result beat, marked by out_valid for one cycle, that cannot be
// held off. Clear and load items finish at once: the result shows in the
// cycle after the accept and busy stays low, so one such item per cycle is
// taken. An allocate item raises busy while the fit search moves through
// the cell chain one partition per clock; its result is registered at the
// end of the scan, as busy drops. Write the policy through cfg_we /
// cfg_wdata only while no item is in flight.
module fixed_partition_fit_allocator_core #(
  parameter int NUM_PARTITIONS = 16,
  parameter int SIZE_BITS      = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_wdata,
  input  logic                               start,
  output logic                               busy,
  input  logic [fpfa_pkg::MODE_W-1:0]        in_mode,
  input  logic [fpfa_pkg::SIZE_IN_W-1:0]     in_size_value,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [fpfa_pkg::IDX_OUT_W-1:0]     out_partition_index,
  output logic [fpfa_pkg::SIZE_OUT_W-1:0]    out_partition_size,
  output logic [fpfa_pkg::FREE_W-1:0]        out_free_total,
  output logic                               out_all_granted
);
  import fpfa_pkg::*;

  localparam int IW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam int CW = $clog2(NUM_PARTITIONS + 1);
  localparam int SW = ((SIZE_BITS > FREE_W) ? SIZE_BITS : FREE_W) + 1;
  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                  state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [SIZE_BITS-1:0]  req_r, req_nxt;
  logic [FREE_W-1:0]     free_r, free_nxt;
  logic                  all_r, all_nxt;
  logic [1:0]            policy_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic [IW-1:0]         out_idx_r, out_idx_nxt;
  logic [SIZE_BITS-1:0]  out_size_r, out_size_nxt;

  logic                  accept, full, commit, grant_ok;
  logic [SIZE_BITS-1:0]  sz_in;
  logic [SW-1:0]         sum_ext;

  cell_ctl_t             ctl   [NUM_PARTITIONS];
  logic                  found [NUM_PARTITIONS];
  logic [IW-1:0]         cidx  [NUM_PARTITIONS];
  logic [SIZE_BITS-1:0]  csize [NUM_PARTITIONS];
  logic [NUM_PARTITIONS-1:0] gnt_vec;

  assign sz_in    = SIZE_BITS'(in_size_value);
  assign busy     = (state_r == S_SCAN);
  assign accept   = start && !busy;
  assign full     = (count_r == CW'(NUM_PARTITIONS));
  assign commit   = busy && (cnt_r == CW'(NUM_PARTITIONS));
  assign grant_ok = found[NUM_PARTITIONS-1] && (csize[NUM_PARTITIONS-1] >= req_r);
  assign sum_ext  = SW'(free_r) + SW'(sz_in);

  // cell chain with per-slot strobes
  for (genvar i = 0; i < NUM_PARTITIONS; i++) begin : g_cell
    logic                 in_found;
    logic [IW-1:0]        in_idx;
    logic [SIZE_BITS-1:0] in_size;

    assign ctl[i].clr = accept && (in_mode == MODE_CLEAR);
    assign ctl[i].ld  = accept && (in_mode == MODE_LOAD) && !full &&
                        (count_r[IW-1:0] == IW'(i));
    assign ctl[i].gnt = commit && grant_ok && (cidx[NUM_PARTITIONS-1] == IW'(i));
    assign gnt_vec[i] = ctl[i].gnt;

    if (i == 0) begin : g_seed
      assign in_found = 1'b0;
      assign in_idx   = '0;
      assign in_size  = '0;
    end else begin : g_link
      assign in_found = found[i-1];
      assign in_idx   = cidx[i-1];
      assign in_size  = csize[i-1];
    end

    fpfa_cell #(
      .SIZE_BITS (SIZE_BITS),
      .IW        (IW),
      .CELL_IDX  (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl[i]),
      .ld_size    (sz_in),
      .policy     (policy_r),
      .req        (req_r),
      .cin_found  (in_found),
      .cin_idx    (in_idx),
      .cin_size   (in_size),
      .cout_found (found[i]),
      .cout_idx   (cidx[i]),
      .cout_size  (csize[i])
    );
  end

  // controller: immediate clear/load, chain scan for allocate
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    count_nxt      = count_r;
    req_nxt        = req_r;
    free_nxt       = free_r;
    all_nxt        = all_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_size_nxt   = out_size_r;

    if (accept) begin
      out_status_nxt = ST_OK;
      out_idx_nxt    = '0;
      out_size_nxt   = '0;
      case (in_mode)
        MODE_CLEAR: begin
          count_nxt     = '0;
          free_nxt      = '0;
          all_nxt       = 1'b1;
          out_valid_nxt = 1'b1;
        end
        MODE_LOAD: begin
          if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            out_idx_nxt = count_r[IW-1:0];
            count_nxt   = count_r + CW'(1);
            if (sum_ext > SW'(FREE_MAX)) begin
              free_nxt = FREE_MAX;
            end else begin
              free_nxt = FREE_W'(sum_ext);
            end
          end
          out_valid_nxt = 1'b1;
        end
        MODE_ALLOC: begin
          req_nxt   = sz_in;
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end
        default: begin
          out_valid_nxt = 1'b1;
        end
      endcase
    end else if (busy) begin
      if (commit) begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (grant_ok) begin
          out_status_nxt = ST_OK;
          out_idx_nxt    = cidx[NUM_PARTITIONS-1];
          out_size_nxt   = csize[NUM_PARTITIONS-1];
          if (SW'(free_r) >= SW'(req_r)) begin
            free_nxt = FREE_W'(SW'(free_r) - SW'(req_r));
          end else begin
            free_nxt = '0;
          end
        end else begin
          out_status_nxt = ST_MISS;
          out_idx_nxt    = '0;
          out_size_nxt   = '0;
          all_nxt        = 1'b0;
        end
      end else begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      count_r     <= '0;
      free_r      <= '0;
      all_r       <= 1'b1;
      policy_r    <= POL_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      count_r     <= count_nxt;
      free_r      <= free_nxt;
      all_r       <= all_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        policy_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_size_r   <= out_size_nxt;
  end

  // drive the result beat
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_partition_index = IDX_OUT_W'(out_idx_r);
  assign out_partition_size  = SIZE_OUT_W'(out_size_r);
  assign out_free_total      = free_r;
  assign out_all_granted     = all_r;

  // an allocate beat always enters the scan
  a_alloc_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == MODE_ALLOC)) |=> busy)
    else $error("allocate beat did not start a scan");

  // at most one slot marked used per grant
  a_one_grant: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(gnt_vec))
    else $error("more than one partition granted");

  // scan counter stays within the chain length
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (cnt_r <= CW'(NUM_PARTITIONS)))
    else $error("scan counter out of range");

  // table-full status only with a full table
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (count_r == CW'(NUM_PARTITIONS)))
    else $error("table full reported with free slots");

endmodule

>>> hdl/fpfa_cell.sv
// One partition slot of the allocator chain: holds size, used and valid,
// and passes the running candidate of the fit search to its neighbor.
// Depends on fpfa_pkg.
module fpfa_cell #(
  parameter int SIZE_BITS = 16,
  parameter int IW        = 4,
  parameter int CELL_IDX  = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fpfa_pkg::cell_ctl_t   ctl,
  input  logic [SIZE_BITS-1:0]  ld_size,
  input  logic [1:0]            policy,
  input  logic [SIZE_BITS-1:0]  req,
  input  logic                  cin_found,
  input  logic [IW-1:0]         cin_idx,
  input  logic [SIZE_BITS-1:0]  cin_size,
  output logic                  cout_found,
  output logic [IW-1:0]         cout_idx,
  output logic [SIZE_BITS-1:0]  cout_size
);
  import fpfa_pkg::*;

  logic                 valid_r, valid_nxt;
  logic                 used_r, used_nxt;
  logic [SIZE_BITS-1:0] size_r;
  logic                 found_r, found_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [SIZE_BITS-1:0] csize_r, csize_nxt;
  logic                 eligible, take;

  // entry state
  always_comb begin
    valid_nxt = valid_r;
    used_nxt  = used_r;
    if (ctl.clr) begin
      valid_nxt = 1'b0;
      used_nxt  = 1'b0;
    end else if (ctl.ld) begin
      valid_nxt = 1'b1;
      used_nxt  = 1'b0;
    end else if (ctl.gnt) begin
      used_nxt  = 1'b1;
    end
  end

  // decide whether this slot replaces the incoming candidate
  always_comb begin
    eligible = valid_r && !used_r && ((policy == POL_WORST) || (size_r >= req));
    case (policy)
      POL_BEST:  take = eligible && (!cin_found || (size_r < cin_size));
      POL_WORST: take = eligible && (!cin_found || (size_r > cin_size));
      default:   take = eligible && !cin_found;
    endcase
    if (take) begin
      found_nxt = 1'b1;
      idx_nxt   = IW'(CELL_IDX);
      csize_nxt = size_r;
    end else begin
      found_nxt = cin_found;
      idx_nxt   = cin_idx;
      csize_nxt = cin_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      used_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      used_r  <= used_nxt;
      found_r <= found_nxt;
    end
  end

  // payload: size and candidate data
  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      size_r <= ld_size;
    end
    idx_r   <= idx_nxt;
    csize_r <= csize_nxt;
  end

  assign cout_found = found_r;
  assign cout_idx   = idx_r;
  assign cout_size  = csize_r;

endmodule
